[design/glr_pkg.sv]
`timescale 1ns / 1ps
package glr_pkg;

  localparam int PIX_W   = 6;
  localparam int COLOR_W = 8;
  localparam int POT_W   = 12;
  localparam int DIV_W   = 8;
  localparam int CNT_W   = 4;
  localparam int ERR_W   = 9;
  localparam int CFG_W   = 1;

  // packet framing
  localparam logic [7:0] HDR_BYTE0  = 8'h80;
  localparam logic [7:0] HDR_BYTE1  = 8'h81;
  localparam logic [7:0] TYPE_BYTE0 = 8'h7F;
  localparam logic [7:0] TYPE_BYTE1 = 8'hFE;

  localparam logic [CNT_W-1:0] POS_HDR0    = 4'd0;
  localparam logic [CNT_W-1:0] POS_HDR1    = 4'd1;
  localparam logic [CNT_W-1:0] POS_TYPE0   = 4'd2;
  localparam logic [CNT_W-1:0] POS_TYPE1   = 4'd3;
  localparam logic [CNT_W-1:0] POS_ENABLE  = 4'd7;
  localparam logic [CNT_W-1:0] POS_ERROR   = 4'd10;
  localparam logic [CNT_W-1:0] MIN_PKT_LEN = 4'd11;
  localparam logic [CNT_W-1:0] CNT_MAX     = 4'd15;

  localparam logic signed [ERR_W-1:0] ERR_BIAS = 9'sd127;
  localparam int BRIGHT_SHIFT = 4;

  // config register indexes
  localparam logic [CFG_W-1:0] REG_CM_PER_PIXEL = 1'd0;
  localparam logic [CFG_W-1:0] REG_DIST_INC     = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_Q,
    ST_SET_M,
    ST_DIV_M,
    ST_EMIT
  } glr_state_e;

  typedef struct packed {
    logic parse;
    logic start;
    logic div_step;
    logic load_mag;
    logic emit;
  } glr_cmd_t;

  typedef struct packed {
    logic out_free;
    logic pix_last;
  } glr_status_t;

endpackage

[design/glr_ctrl.sv]
`timescale 1ns / 1ps
module glr_ctrl
  import glr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        cmd_i,
  output logic        in_ready_o,
  input  glr_status_t status_i,
  output glr_cmd_t    cmd_o
);

  localparam int STEP_W = $clog2(DIV_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_W - 1);

  glr_state_e state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (cmd_i) begin
            cmd_o.start = 1'b1;
            step_d      = '0;
            state_d     = ST_DIV_Q;
          end else begin
            cmd_o.parse = 1'b1;
          end
        end
      end
      ST_DIV_Q: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == STEP_LAST) begin
          state_d = ST_SET_M;
        end
      end
      ST_SET_M: begin
        cmd_o.load_mag = 1'b1;
        step_d         = '0;
        state_d        = ST_DIV_M;
      end
      ST_DIV_M: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == STEP_LAST) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.pix_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[design/glr_dp.sv]
`timescale 1ns / 1ps
module glr_dp
  import glr_pkg::*;
#(
  parameter int NUM_PIXELS = 63
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  glr_cmd_t           cmd_i,
  output glr_status_t        status_o,
  input  logic [7:0]         data_byte_i,
  input  logic               first_byte_i,
  input  logic               last_byte_i,
  input  logic [POT_W-1:0]   pot_sample_i,
  input  logic               cfg_valid_i,
  input  logic [CFG_W-1:0]   cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [PIX_W-1:0]   pixel_index_o,
  output logic [COLOR_W-1:0] red_o,
  output logic [COLOR_W-1:0] green_o,
  output logic [COLOR_W-1:0] blue_o,
  output logic               last_pixel_o
);

  localparam int CENTER = (NUM_PIXELS - 1) / 2;
  localparam logic [PIX_W:0]   CTR      = (PIX_W + 1)'(CENTER);
  localparam logic [DIV_W-1:0] CTR_Q    = DIV_W'(CENTER);
  localparam logic [PIX_W-1:0] PIX_LAST = PIX_W'(NUM_PIXELS - 1);

  // config registers
  logic [7:0] cm_per_pixel_q, dist_inc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cm_per_pixel_q <= 8'd2;
      dist_inc_q     <= 8'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CM_PER_PIXEL: cm_per_pixel_q <= cfg_data_i;
        REG_DIST_INC:     dist_inc_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // packet parser
  logic                    enabled_q, enabled_d;
  logic signed [ERR_W-1:0] err_q, err_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    hm_q, hm_d;
  logic                    pend_en_q, pend_en_d;
  logic [7:0]              pend_err_q, pend_err_d;
  logic [CNT_W-1:0]        cnt_cur;

  always_comb begin
    enabled_d  = enabled_q;
    err_d      = err_q;
    cnt_d      = cnt_q;
    hm_d       = hm_q;
    pend_en_d  = pend_en_q;
    pend_err_d = pend_err_q;
    cnt_cur    = first_byte_i ? '0 : cnt_q;
    if (cmd_i.parse) begin
      hm_d = first_byte_i ? 1'b1 : hm_q;
      case (cnt_cur)
        POS_HDR0:   if (data_byte_i != HDR_BYTE0)  hm_d = 1'b0;
        POS_HDR1:   if (data_byte_i != HDR_BYTE1)  hm_d = 1'b0;
        POS_TYPE0:  if (data_byte_i != TYPE_BYTE0) hm_d = 1'b0;
        POS_TYPE1:  if (data_byte_i != TYPE_BYTE1) hm_d = 1'b0;
        POS_ENABLE: pend_en_d  = (data_byte_i != 8'd0);
        POS_ERROR:  pend_err_d = data_byte_i;
        default: ;
      endcase
      cnt_d = (cnt_cur < CNT_MAX) ? cnt_cur + 1'b1 : cnt_cur;
      if (last_byte_i) begin
        if (hm_d && cnt_d >= MIN_PKT_LEN) begin
          enabled_d = pend_en_d;
          err_d     = $signed({1'b0, pend_err_d}) - ERR_BIAS;
        end
        hm_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q  <= 1'b0;
      err_q      <= '0;
      cnt_q      <= '0;
      hm_q       <= 1'b0;
      pend_en_q  <= 1'b0;
      pend_err_q <= '0;
    end else begin
      enabled_q  <= enabled_d;
      err_q      <= err_d;
      cnt_q      <= cnt_d;
      hm_q       <= hm_d;
      pend_en_q  <= pend_en_d;
      pend_err_q <= pend_err_d;
    end
  end

  // shared restoring divider, one quotient bit per step
  logic [DIV_W-1:0] quo_q, rem_q, dvs_q;
  logic [DIV_W:0]   trial;
  logic             ge;
  logic [DIV_W-1:0] q_fix;
  logic [ERR_W-1:0] err_abs;
  logic             err_neg;

  assign err_neg = err_q[ERR_W-1];
  assign err_abs = err_neg ? ERR_W'(-err_q) : ERR_W'(err_q);
  assign trial   = {rem_q, quo_q[DIV_W-1]};
  assign ge      = trial >= {1'b0, dvs_q};
  // zero divisor or zero quotient both mean one
  assign q_fix   = (dist_inc_q == '0 || quo_q == '0) ? DIV_W'(1) : quo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      quo_q <= cm_per_pixel_q;
      rem_q <= '0;
      dvs_q <= dist_inc_q;
    end else if (cmd_i.load_mag) begin
      quo_q <= err_abs[DIV_W-1:0];
      rem_q <= '0;
      dvs_q <= q_fix;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[DIV_W-2:0], ge};
      rem_q <= ge ? DIV_W'(trial - {1'b0, dvs_q}) : trial[DIV_W-1:0];
    end
  end

  // brightness and pixel sweep
  logic [COLOR_W-1:0] bright_q;
  logic [PIX_W-1:0]   pix_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      bright_q <= COLOR_W'(pot_sample_i >> BRIGHT_SHIFT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
    end else if (cmd_i.start) begin
      pix_q <= '0;
    end else if (cmd_i.emit) begin
      pix_q <= pix_q + 1'b1;
    end
  end

  logic [PIX_W:0] mag_c, pi;
  logic           is_r, is_g, is_b;

  assign mag_c = (quo_q > CTR_Q) ? CTR : {1'b0, quo_q[PIX_W-1:0]};
  assign pi    = {1'b0, pix_q};

  always_comb begin
    is_r = 1'b0;
    is_g = 1'b0;
    is_b = 1'b0;
    if (!enabled_q) begin
      if (pi == CTR) is_b = 1'b1;
      else if (pi < CTR && pi + 7'd4 > CTR) is_g = 1'b1;
      else if (pi > CTR && pi < CTR + 7'd4) is_r = 1'b1;
    end else begin
      if (pi == CTR && mag_c == '0) is_b = 1'b1;
      else if (err_neg && mag_c != '0 && pi + mag_c >= CTR && pi < CTR) is_g = 1'b1;
      else if (!err_neg && mag_c != '0 && pi > CTR && pi <= CTR + mag_c) is_r = 1'b1;
    end
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      pixel_index_o <= pix_q;
      red_o         <= is_r ? bright_q : '0;
      green_o       <= is_g ? bright_q : '0;
      blue_o        <= is_b ? bright_q : '0;
      last_pixel_o  <= (pix_q == PIX_LAST);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.pix_last = (pix_q == PIX_LAST);

endmodule

[design/guidance_lightbar_renderer.sv]
`timescale 1ns / 1ps
// Guidance lightbar renderer.
// Input channel (in_valid_i/in_ready_o): cmd_i = 0 sends one packet byte with
// first/last markers; cmd_i = 1 is a refresh request carrying a pot sample.
// A guidance packet (header 80 81, type 7F FE, 11 bytes or more) updates the
// enable flag and the cross-track error when its last byte arrives.
// Output channel (out_valid_o/out_ready_i): a refresh yields NUM_PIXELS
// pixel colors, index 0 first, last_pixel_o on the final one.
// Config port (cfg_valid_i/cfg_ready_o, always ready): index 0 cm_per_pixel,
// index 1 dist_inc; write only while the block is idle.
// Packet bytes are taken back to back while the block is idle. A refresh
// runs two 8-step divisions on one shared restoring divider (cm_per_pixel /
// dist_inc, then |error| / quotient) with a setup state between them, then
// registers one pixel per cycle while the output is not stalled. The input
// is not ready from a refresh request until its last pixel is registered.
// A stalled receiver holds the output register and the pixel sweep waits;
// the last pixel may still sit in the output register while new requests
// are taken. Reset restores cm_per_pixel = 2, dist_inc = 1, guidance off.
module guidance_lightbar_renderer
  import glr_pkg::*;
#(
  parameter int NUM_PIXELS = 63
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic [7:0]         data_byte_i,
  input  logic               first_byte_i,
  input  logic               last_byte_i,
  input  logic [POT_W-1:0]   pot_sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [PIX_W-1:0]   pixel_index_o,
  output logic [COLOR_W-1:0] red_o,
  output logic [COLOR_W-1:0] green_o,
  output logic [COLOR_W-1:0] blue_o,
  output logic               last_pixel_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CFG_W-1:0]   cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  glr_cmd_t    cmd;
  glr_status_t status;

  assign cfg_ready_o = 1'b1;

  glr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  glr_dp #(
    .NUM_PIXELS (NUM_PIXELS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .data_byte_i   (data_byte_i),
    .first_byte_i  (first_byte_i),
    .last_byte_i   (last_byte_i),
    .pot_sample_i  (pot_sample_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_index_o (pixel_index_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule

[design/glr_checker.sv]
`timescale 1ns / 1ps
module glr_checker
  import glr_pkg::*;
#(
  parameter int NUM_PIXELS = 63
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               cmd_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [PIX_W-1:0]   pixel_index_o,
  input logic [COLOR_W-1:0] red_o,
  input logic [COLOR_W-1:0] green_o,
  input logic [COLOR_W-1:0] blue_o,
  input logic               last_pixel_o
);

  // stalled pixel holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_index_o)
      && $stable(last_pixel_o))
    else $error("stalled pixel changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_pixel_o |-> pixel_index_o == PIX_W'(NUM_PIXELS - 1))
    else $error("last pixel at wrong index");

  // only the final pixel of a refresh may wait while requests are taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && out_valid_o |-> last_pixel_o)
    else $error("request taken mid-refresh");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i |=> !in_ready_o)
    else $error("refresh did not block the input");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && red_o != '0 |-> green_o == '0 && blue_o == '0)
    else $error("pixel has more than one color");

endmodule

bind guidance_lightbar_renderer glr_checker #(
  .NUM_PIXELS (NUM_PIXELS)
) u_glr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .cmd_i         (cmd_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .pixel_index_o (pixel_index_o),
  .red_o         (red_o),
  .green_o       (green_o),
  .blue_o        (blue_o),
  .last_pixel_o  (last_pixel_o)
);
